### rtl/mask_iou_mutual_best_match_top_assert.svh
// Assertion macros for the RTL; included by mibm_merge.sv.
`ifndef MASK_IOU_MUTUAL_BEST_MATCH_TOP_ASSERT_SVH
`define MASK_IOU_MUTUAL_BEST_MATCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MIBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MIBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MIBM_ASSERT(lbl, prop, msg)
`define MIBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/mibm_pkg.sv
package mibm_pkg;

    localparam int MAX_DET    = 8;
    localparam int MAX_INST   = 8;
    localparam int CNT_W      = 20;
    localparam int ID_W       = 16;
    localparam int LANE_BITS  = 8;
    localparam int DET_IDX_W  = $clog2(MAX_DET);
    localparam int INST_IDX_W = $clog2(MAX_INST);
    localparam int UN_W       = CNT_W + 1;
    localparam int PROD_W     = CNT_W + UN_W;
    localparam int THR_W      = 16;
    localparam int THP_W      = THR_W + UN_W;
    localparam int NUM_W      = 4;

    localparam logic [1:0] REG_THR  = 2'd0;
    localparam logic [1:0] REG_DETS = 2'd1;
    localparam logic [1:0] REG_INST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_INIT,
        S_ROW_MUL,
        S_ROW_CMP,
        S_COL_INIT,
        S_COL_MUL,
        S_COL_CMP,
        S_TH_MUL,
        S_TH_CMP,
        S_OUT_WAIT,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic                  clear;
        logic                  load_best;
        logic                  mul;
        logic                  upd;
        logic [INST_IDX_W-1:0] col;
    } t_lane_ctl;

    // zero union stands for IoU 0, i.e. 0/1
    function automatic logic [UN_W-1:0] fix_den(input logic [UN_W-1:0] u);
        return (u == '0) ? UN_W'(1) : u;
    endfunction

    function automatic logic [CNT_W-1:0] fix_num(input logic [CNT_W-1:0] ov,
                                                 input logic [UN_W-1:0] u);
        return (u == '0) ? '0 : ov;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

endpackage

### rtl/mask_iou_mutual_best_match_top.sv
// Pixels: one per cycle, accepted while the block is idle; slot loads likewise.
// Frame end: after the last pixel the block runs the row search (an init step, then a
// multiply and a compare step per further instance; init only when M is 0 or 1), then per
// detection a column search plus threshold multiply and compare until its result shows,
// then waits for it to be taken; after the last result it clears the counters.
// Reset (synchronous, active low) clears all counters, idles the sequencer and loads
// the register defaults; slot IDs are not reset.
module mask_iou_mutual_best_match_top
    import mibm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [2:0]           i_slot_index,
    input  logic [ID_W-1:0]      i_slot_instance_id,
    input  logic [LANE_BITS-1:0] i_detection_bits,
    input  logic [LANE_BITS-1:0] i_instance_bits,
    input  logic                 i_last_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_detection_index,
    output logic                 o_matched,
    output logic [ID_W-1:0]      o_matched_id,
    output logic                 o_last_result
);

    logic [THR_W-1:0]      r_thr;
    logic [NUM_W-1:0]      r_dets;
    logic [NUM_W-1:0]      r_insts;
    logic [ID_W-1:0]       r_slot [MAX_INST];
    logic [CNT_W-1:0]      r_ia [MAX_INST];

    t_lane_ctl             ctl;
    logic                  accept;
    logic                  pix;
    logic [NUM_W-1:0]      kn;
    logic [NUM_W-1:0]      mn;
    logic [CNT_W-1:0]      lane_ov [MAX_DET];
    logic [UN_W-1:0]       lane_un [MAX_DET];
    logic [INST_IDX_W-1:0] lane_best [MAX_DET];
    logic                  wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign accept = i_valid && o_ready;
    assign pix    = accept && i_opcode;
    assign kn     = (r_dets > NUM_W'(MAX_DET)) ? NUM_W'(MAX_DET) : r_dets;
    assign mn     = (r_insts > NUM_W'(MAX_INST)) ? NUM_W'(MAX_INST) : r_insts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_W'(16384);
            r_dets  <= NUM_W'(8);
            r_insts <= NUM_W'(8);
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_THR:  r_thr   <= pwdata[THR_W-1:0];
                REG_DETS: r_dets  <= pwdata[NUM_W-1:0];
                REG_INST: r_insts <= pwdata[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THR:  prdata = 32'(r_thr);
            REG_DETS: prdata = 32'(r_dets);
            REG_INST: prdata = 32'(r_insts);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_opcode) r_slot[i_slot_index[INST_IDX_W-1:0]] <= i_slot_instance_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clear) begin
            for (int m = 0; m < MAX_INST; m++) r_ia[m] <= '0;
        end else if (pix) begin
            for (int m = 0; m < MAX_INST; m++) begin
                if (i_instance_bits[m]) r_ia[m] <= sat_inc(r_ia[m]);
            end
        end
    end

    for (genvar k = 0; k < MAX_DET; k++) begin : g_lane
        mibm_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_pix_en    (pix && i_detection_bits[k]),
            .i_inst_bits (i_instance_bits),
            .i_inst_area (r_ia[ctl.col]),
            .o_ov        (lane_ov[k]),
            .o_un        (lane_un[k]),
            .o_best_col  (lane_best[k])
        );
    end

    mibm_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (pix && i_last_pixel),
        .i_kn              (kn),
        .i_mn              (mn),
        .i_thr             (r_thr),
        .i_ov              (lane_ov),
        .i_un              (lane_un),
        .i_best_col        (lane_best),
        .i_slot_ids        (r_slot),
        .i_ready           (i_ready),
        .o_ctl             (ctl),
        .o_in_ready        (o_ready),
        .o_valid           (o_valid),
        .o_detection_index (o_detection_index),
        .o_matched         (o_matched),
        .o_matched_id      (o_matched_id),
        .o_last_result     (o_last_result)
    );

endmodule

### rtl/mibm_lane.sv
module mibm_lane
    import mibm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_ctl             i_ctl,
    input  logic                  i_pix_en,
    input  logic [LANE_BITS-1:0]  i_inst_bits,
    input  logic [CNT_W-1:0]      i_inst_area,
    output logic [CNT_W-1:0]      o_ov,
    output logic [UN_W-1:0]       o_un,
    output logic [INST_IDX_W-1:0] o_best_col
);

    logic [CNT_W-1:0]      r_ov [MAX_INST];
    logic [CNT_W-1:0]      r_area;
    logic [CNT_W-1:0]      r_best_ov;
    logic [UN_W-1:0]       r_best_un;
    logic [INST_IDX_W-1:0] r_best_col;
    logic [PROD_W-1:0]     r_pa;
    logic [PROD_W-1:0]     r_pb;
    logic [CNT_W-1:0]      sel_ov;
    logic [UN_W-1:0]       sel_un;

    assign sel_ov = r_ov[i_ctl.col];
    assign sel_un = UN_W'(r_area) + UN_W'(i_inst_area) - UN_W'(sel_ov);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0;
            for (int m = 0; m < MAX_INST; m++) r_ov[m] <= '0;
        end else if (i_ctl.clear) begin
            r_area <= '0;
            for (int m = 0; m < MAX_INST; m++) r_ov[m] <= '0;
        end else if (i_pix_en) begin
            r_area <= sat_inc(r_area);
            for (int m = 0; m < MAX_INST; m++) begin
                if (i_inst_bits[m]) r_ov[m] <= sat_inc(r_ov[m]);
            end
        end
    end

    // row search: a strict win moves the best column, so ties keep the lower one
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_best) begin
            r_best_ov  <= sel_ov;
            r_best_un  <= sel_un;
            r_best_col <= i_ctl.col;
        end else if (i_ctl.upd && (r_pa > r_pb)) begin
            r_best_ov  <= sel_ov;
            r_best_un  <= sel_un;
            r_best_col <= i_ctl.col;
        end
        if (i_ctl.mul) begin
            r_pa <= PROD_W'(fix_num(sel_ov, sel_un)) * PROD_W'(fix_den(r_best_un));
            r_pb <= PROD_W'(fix_num(r_best_ov, r_best_un)) * PROD_W'(fix_den(sel_un));
        end
    end

    assign o_ov       = sel_ov;
    assign o_un       = sel_un;
    assign o_best_col = r_best_col;

endmodule

### rtl/mibm_merge.sv
`include "mask_iou_mutual_best_match_top_assert.svh"
module mibm_merge
    import mibm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_kn,
    input  logic [NUM_W-1:0]      i_mn,
    input  logic [THR_W-1:0]      i_thr,
    input  logic [CNT_W-1:0]      i_ov [MAX_DET],
    input  logic [UN_W-1:0]       i_un [MAX_DET],
    input  logic [INST_IDX_W-1:0] i_best_col [MAX_DET],
    input  logic [ID_W-1:0]       i_slot_ids [MAX_INST],
    input  logic                  i_ready,
    output t_lane_ctl             o_ctl,
    output logic                  o_in_ready,
    output logic                  o_valid,
    output logic [DET_IDX_W-1:0]  o_detection_index,
    output logic                  o_matched,
    output logic [ID_W-1:0]       o_matched_id,
    output logic                  o_last_result
);

    t_state                r_state, n_state;
    logic [NUM_W-1:0]      r_j;
    logic [DET_IDX_W-1:0]  r_k;
    logic [DET_IDX_W-1:0]  r_bk;
    logic [CNT_W-1:0]      r_bk_ov;
    logic [UN_W-1:0]       r_bk_un;
    logic [PROD_W-1:0]     r_pa;
    logic [PROD_W-1:0]     r_pb;
    logic [THP_W-1:0]      r_thp;
    logic                  r_valid;
    logic [DET_IDX_W-1:0]  r_det_idx;
    logic                  r_matched;
    logic [ID_W-1:0]       r_id;
    logic                  r_last;

    logic [DET_IDX_W-1:0]  j_det;
    logic [INST_IDX_W-1:0] bm;
    logic                  is_last_k;
    logic                  hit;

    assign j_det     = r_j[DET_IDX_W-1:0];
    assign bm        = i_best_col[r_k];
    assign is_last_k = ((NUM_W'(r_k) + NUM_W'(1)) == i_kn);
    assign hit       = (i_mn != '0) && (r_bk == r_k) && (i_un[r_k] != '0) &&
                       ({1'b0, i_ov[r_k], {THR_W{1'b0}}} > r_thp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state         = r_state;
        o_ctl.clear     = 1'b0;
        o_ctl.load_best = 1'b0;
        o_ctl.mul       = 1'b0;
        o_ctl.upd       = 1'b0;
        o_ctl.col       = bm;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = (i_kn == '0) ? S_CLEAR : S_ROW_INIT;
            end
            S_ROW_INIT: begin
                o_ctl.col       = '0;
                o_ctl.load_best = 1'b1;
                n_state         = (i_mn <= NUM_W'(1)) ? S_COL_INIT : S_ROW_MUL;
            end
            S_ROW_MUL: begin
                o_ctl.col = r_j[INST_IDX_W-1:0];
                o_ctl.mul = 1'b1;
                n_state   = S_ROW_CMP;
            end
            S_ROW_CMP: begin
                o_ctl.col = r_j[INST_IDX_W-1:0];
                o_ctl.upd = 1'b1;
                n_state   = ((r_j + NUM_W'(1)) == i_mn) ? S_COL_INIT : S_ROW_MUL;
            end
            S_COL_INIT: n_state = (i_kn <= NUM_W'(1)) ? S_TH_MUL : S_COL_MUL;
            S_COL_MUL:  n_state = S_COL_CMP;
            S_COL_CMP:  n_state = ((r_j + NUM_W'(1)) == i_kn) ? S_TH_MUL : S_COL_MUL;
            S_TH_MUL:   n_state = S_TH_CMP;
            S_TH_CMP:   n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (i_ready) n_state = r_last ? S_CLEAR : S_COL_INIT;
            end
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    r_j <= NUM_W'(1);
                end
                S_ROW_CMP: r_j <= r_j + NUM_W'(1);
                S_COL_INIT: r_j <= NUM_W'(1);
                S_COL_CMP: r_j <= r_j + NUM_W'(1);
                S_TH_CMP: r_valid <= 1'b1;
                S_OUT_WAIT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_k     <= r_k + DET_IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // column search over the detection lanes at the row's best column, then the threshold test and result capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_COL_INIT) begin
            r_bk    <= '0;
            r_bk_ov <= i_ov[0];
            r_bk_un <= i_un[0];
        end else if (r_state == S_COL_CMP && (r_pa > r_pb)) begin
            r_bk    <= j_det;
            r_bk_ov <= i_ov[j_det];
            r_bk_un <= i_un[j_det];
        end
        if (r_state == S_COL_MUL) begin
            r_pa <= PROD_W'(fix_num(i_ov[j_det], i_un[j_det])) * PROD_W'(fix_den(r_bk_un));
            r_pb <= PROD_W'(fix_num(r_bk_ov, r_bk_un)) * PROD_W'(fix_den(i_un[j_det]));
        end
        if (r_state == S_TH_MUL) r_thp <= THP_W'(i_thr) * THP_W'(i_un[r_k]);
        if (r_state == S_TH_CMP) begin
            r_det_idx <= r_k;
            r_matched <= hit;
            r_id      <= hit ? i_slot_ids[bm] : '0;
            r_last    <= is_last_k;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_valid           = r_valid;
    assign o_detection_index = r_det_idx;
    assign o_matched         = r_matched;
    assign o_matched_id      = r_id;
    assign o_last_result     = r_last;

    `MIBM_ASSERT(a_last_clears, (r_state == S_OUT_WAIT && i_ready && r_last) |=> (r_state == S_CLEAR), "last result must lead to clear")
    `MIBM_ASSERT(a_idx_in_range, r_valid |-> (NUM_W'(r_det_idx) < i_kn), "result index beyond active detections")
    `MIBM_ASSERT(a_no_match_empty, (r_valid && r_matched) |-> (i_mn != '0), "match reported with no instances")
    `MIBM_ASSERT(a_valid_only_wait, r_valid |-> (r_state == S_OUT_WAIT), "result shown outside wait state")
    `MIBM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_valid), "reset must idle the sequencer")

endmodule

### tb/sv/tb.sv
module tb;
    import mibm_pkg::*;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
    localparam logic [3:0] ADDR_THR  = {REG_THR, 2'b00};
    localparam logic [3:0] ADDR_DETS = {REG_DETS, 2'b00};
    localparam logic [3:0] ADDR_INST = {REG_INST, 2'b00};
    localparam logic [3:0] ADDR_NONE = 4'd12;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  det;
        logic        hit;
        logic [15:0] id;
        logic        last;
    } t_match;

    typedef struct {
        logic        op;
        logic [2:0]  slot;
        logic [15:0] id;
        logic [7:0]  dbits;
        logic [7:0]  ibits;
        logic        last;
        logic        typed;
        logic [7:0]  hit_mask;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_ready;
    logic        i_opcode;
    logic [2:0]  i_slot_index;
    logic [15:0] i_slot_instance_id;
    logic [7:0]  i_detection_bits, i_instance_bits;
    logic        i_last_pixel;
    logic        o_valid, i_ready;
    logic [2:0]  o_detection_index;
    logic        o_matched;
    logic [15:0] o_matched_id;
    logic        o_last_result;

    mask_iou_mutual_best_match_top u_dut (.*);

    // predictor state
    logic [15:0] thr_q;
    logic [3:0]  dets_q, inst_q;
    logic [19:0] ovl[8][8];
    logic [19:0] darea[8], iarea[8];
    logic [15:0] slot_id[8];

    t_match match_q[$];
    int errors = 0;
    bit gaps_on = 1;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3000000);
        $display("mask_iou_mutual_best_match_top test failed");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [19:0] sat_bump(input logic [19:0] c);
        return (c == 20'hFFFFF) ? c : c + 20'd1;
    endfunction

    function automatic bit iou_gt(input longint unsigned an, input longint unsigned ad,
                                  input longint unsigned bn, input longint unsigned bd);
        if (ad == 0) begin an = 0; ad = 1; end
        if (bd == 0) begin bn = 0; bd = 1; end
        return an * bd > bn * ad;
    endfunction

    function automatic longint unsigned union_sz(input int k, input int m);
        return longint'(darea[k]) + longint'(iarea[m]) - longint'(ovl[k][m]);
    endfunction

    // apply one accepted request; returns the mask of matched detections
    function automatic logic [7:0] match_frame(input logic op, input logic [2:0] slot,
                                               input logic [15:0] id, input logic [7:0] db,
                                               input logic [7:0] ib, input logic last);
        int kn, mn, bm, bk;
        longint unsigned un;
        t_match r;
        logic [7:0] hits;
        hits = '0;
        if (op == OP_LOAD) begin
            slot_id[slot] = id;
            return hits;
        end
        for (int k = 0; k < 8; k++)
            if (db[k]) begin
                darea[k] = sat_bump(darea[k]);
                for (int m = 0; m < 8; m++)
                    if (ib[m]) ovl[k][m] = sat_bump(ovl[k][m]);
            end
        for (int m = 0; m < 8; m++)
            if (ib[m]) iarea[m] = sat_bump(iarea[m]);
        if (!last) return hits;
        kn = (dets_q > 8) ? 8 : dets_q;
        mn = (inst_q > 8) ? 8 : inst_q;
        for (int k = 0; k < kn; k++) begin
            r = '0;
            r.det = k[2:0];
            r.last = (k + 1 == kn);
            if (mn > 0) begin
                bm = 0;
                bk = 0;
                for (int j = 1; j < mn; j++)
                    if (iou_gt(ovl[k][j], union_sz(k, j), ovl[k][bm], union_sz(k, bm)))
                        bm = j;
                for (int j = 1; j < kn; j++)
                    if (iou_gt(ovl[j][bm], union_sz(j, bm), ovl[bk][bm], union_sz(bk, bm)))
                        bk = j;
                un = union_sz(k, bm);
                if (bk == k && un != 0 &&
                    (longint'(ovl[k][bm]) << 16) > longint'(thr_q) * un) begin
                    r.hit = 1'b1;
                    r.id = slot_id[bm];
                    hits[k] = 1'b1;
                end
            end
            match_q.push_back(r);
        end
        for (int k = 0; k < 8; k++) begin
            darea[k] = '0;
            iarea[k] = '0;
            for (int m = 0; m < 8; m++) ovl[k][m] = '0;
        end
        return hits;
    endfunction

    task automatic send_request(input logic op, input logic [2:0] slot, input logic [15:0] id,
                                input logic [7:0] db, input logic [7:0] ib, input logic last,
                                output logic [7:0] hits);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_slot_index <= slot;
        i_slot_instance_id <= id;
        i_detection_bits <= db;
        i_instance_bits <= ib;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        hits = match_frame(op, slot, id, db, ib, last);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_THR:  thr_q = data[15:0];
            ADDR_DETS: dets_q = data[3:0];
            ADDR_INST: inst_q = data[3:0];
            default: ;
        endcase
    endtask

    // result side: random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_valid && i_ready) begin
            if (match_q.size() == 0) begin
                report("unexpected result, detection", o_detection_index, 0);
            end else begin
                want = match_q.pop_front();
                if (o_detection_index != want.det)
                    report("detection_index", o_detection_index, want.det);
                if (o_matched != want.hit) report("matched", o_matched, want.hit);
                if (o_matched_id != want.id) report("matched_id", o_matched_id, want.id);
                if (o_last_result != want.last)
                    report("last_result", o_last_result, want.last);
            end
        end
    end

    t_row rows[] = '{
        '{OP_LOAD, 3'd0, 16'd1, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd1, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd2, 16'h1234, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd3, 16'h8000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd4, 16'h00FF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd5, 16'h5A5A, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd6, 16'hA5A5, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_LOAD, 3'd7, 16'h7FFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h01, 8'h01, 1'b1, 1'b1, 8'h01},
        // all masks identical: ties go to the lowest index
        '{OP_PIXEL, 3'd0, 16'h0000, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1, 8'h01},
        // no overlap anywhere
        '{OP_PIXEL, 3'd0, 16'h0000, 8'hFF, 8'h00, 1'b1, 1'b1, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h80, 8'h80, 1'b0, 1'b0, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h40, 8'h40, 1'b1, 1'b1, 8'hC0},
        // load ignores the pixel fields
        '{OP_LOAD, 3'd0, 16'd1, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h03, 8'h01, 1'b1, 1'b1, 8'h01},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h0F, 8'h3C, 1'b0, 1'b0, 8'h00},
        '{OP_PIXEL, 3'd0, 16'h0000, 8'h0C, 8'h0C, 1'b1, 1'b0, 8'h00}
    };

    logic [15:0] thr_set[] = '{16'd0, 16'd65535, 16'd16384, 16'd32768, 16'd1, 16'd49152};
    logic [3:0]  dets_set[] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
    logic [3:0]  inst_set[] = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd8, 4'd4, 4'd8};

    initial begin
        logic [7:0] hits, db, ib;
        int sent, phase, npix;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_opcode = 0; i_slot_index = 0; i_slot_instance_id = 0;
        i_detection_bits = 0; i_instance_bits = 0; i_last_pixel = 0; i_ready = 0;
        thr_q = 16'd16384; dets_q = 4'd8; inst_q = 4'd8;
        for (int k = 0; k < 8; k++) begin
            darea[k] = '0;
            iarea[k] = '0;
            slot_id[k] = '0;
            for (int m = 0; m < 8; m++) ovl[k][m] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_request(rows[r].op, rows[r].slot, rows[r].id, rows[r].dbits,
                         rows[r].ibits, rows[r].last, hits);
            if (rows[r].typed && hits != rows[r].hit_mask)
                report("directed hit mask", hits, rows[r].hit_mask);
        end
        drain();
        write_reg(ADDR_NONE, 32'hFFFF_FFFF);

        sent = 0;
        phase = 0;
        while (sent < 380) begin
            drain();
            write_reg(ADDR_THR, (phase < thr_set.size()) ? 32'(thr_set[phase])
                                                         : 32'($urandom_range(0, 65535)));
            write_reg(ADDR_DETS, 32'(dets_set[phase % dets_set.size()]));
            write_reg(ADDR_INST, 32'(inst_set[phase % inst_set.size()]));
            gaps_on = (sent < 320);
            repeat (6) begin
                npix = $urandom_range(1, 10);
                for (int p = 0; p < npix; p++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_request(OP_LOAD, 3'($urandom_range(0, 7)),
                                     16'($urandom_range(1, 65535)),
                                     8'($urandom), 8'($urandom), 1'($urandom), hits);
                    end else begin
                        db = 8'($urandom);
                        ib = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                         : db ^ (8'h1 << $urandom_range(0, 7));
                        send_request(OP_PIXEL, 3'($urandom), 16'($urandom), db, ib,
                                     p == npix - 1, hits);
                    end
                    sent++;
                end
            end
            phase++;
        end
        drain();
        if (match_q.size() != 0) report("results still pending", match_q.size(), 0);
        if (errors == 0) begin
            $display("mask_iou_mutual_best_match_top test passed");
        end else begin
            $display("mask_iou_mutual_best_match_top test failed");
        end
        $finish;
    end

endmodule
